// ----- rtl/ltc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Types, character codes and character-class functions for the Lua token
// classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_NUMBER  = 3'd1,
        KIND_STRING  = 3'd2,
        KIND_SPACE   = 3'd3,
        KIND_COMMENT = 3'd4,
        KIND_SYMBOL  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_SPACE   = 3'd4,
        MODE_COMMENT = 3'd5
    } mode_t;

    // Comment phases.
    localparam logic [1:0] PH_DASH    = 2'd0;
    localparam logic [1:0] PH_BRACKET = 2'd1;
    localparam logic [1:0] PH_LINE    = 2'd2;
    localparam logic [1:0] PH_BLOCK   = 2'd3;

    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       first;
        logic       done;
    } result_t;

    // Outcome of classifying a byte that begins a new token.
    typedef struct packed {
        mode_t mode;
        logic  hold;
        kind_t kind;
        logic  quote_dq;
    } start_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

    function automatic start_t start_token(input logic [7:0] b, input logic fin);
        start_t s;
        s.mode     = MODE_IDLE;
        s.hold     = 1'b0;
        s.kind     = KIND_SYMBOL;
        s.quote_dq = 1'b0;
        if (is_space(b)) begin
            s.mode = MODE_SPACE;
            s.kind = KIND_SPACE;
        end else if (b == CH_DASH || b == CH_DOT) begin
            s.hold = ~fin;
        end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            s.mode     = MODE_STRING;
            s.kind     = KIND_STRING;
            s.quote_dq = (b == CH_DQUOTE);
        end else if (is_alpha(b) || b == CH_UNDER) begin
            s.mode = MODE_IDENT;
            s.kind = KIND_IDENT;
        end else if (is_digit(b)) begin
            s.mode = MODE_NUMBER;
            s.kind = KIND_NUMBER;
        end
        return s;
    endfunction

endpackage

// ----- rtl/lua_token_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lua_token_classifier
// Tags each Lua source byte with its token class and a token-start flag.
// ----------------------------------------------------------------------------
// Usage: source bytes enter on the s_axis channel, one item per byte, with
// s_axis_tlast on the last byte of a source. Classified bytes leave on the
// m_axis channel in input order: the byte in tdata, kind and start flag in
// tuser, and m_axis_tlast on the last result of the source.
// Results are registered in the queue when a byte is accepted; m_axis is
// driven from the queue head. The block takes one item per cycle while
// s_axis_tready is high. A '-' or '.' that may open a longer token, unless
// it is the last byte of a source, is held and produces no result; the next
// byte then produces one or two results. Results go into a four-entry queue,
// and s_axis_tready is high while the queue holds at most two results, so
// an accepted byte always finds room for its results.
// When the receiver stalls, the queue fills and s_axis_tready drops; no
// result is lost. Reset empties the queue and returns the lexer state to
// "between tokens"; the last byte of a source does the same for the lexer
// state, so the next byte begins a new source.
// ----------------------------------------------------------------------------
module lua_token_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [2:0] token_kind, [3] token_start
    output logic       m_axis_tlast    // stream_done
);
    import ltc_pkg::*;

    // Lexer state.
    mode_t      mode_reg, mode_next;
    logic [1:0] phase_reg, phase_next;
    logic       close_reg, close_next;
    logic       quote_dq_reg, quote_dq_next;
    logic       escape_reg, escape_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;

    // Result queue.
    result_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic       accept;
    logic       pop;
    logic [7:0] b;
    logic       fin;
    start_t     st;
    logic       do_start;
    logic       lead;
    logic [1:0] n_res;
    result_t    res0, res1;

    assign b      = s_axis_tdata;
    assign fin    = s_axis_tlast;
    assign st     = start_token(b, fin);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    // Room for two results keeps the ready path free of the output side.
    assign s_axis_tready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    // Classification of one byte: at most two results per item.
    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        close_next      = close_reg;
        quote_dq_next   = quote_dq_reg;
        escape_next     = escape_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        do_start        = 1'b0;
        lead            = 1'b0;
        n_res           = 2'd0;
        res0            = '{data: b, kind: KIND_SYMBOL, first: 1'b0, done: 1'b0};
        res1            = '{data: b, kind: KIND_SYMBOL, first: 1'b0, done: 1'b0};

        if (held_valid_reg) begin
            held_valid_next = 1'b0;
            held_byte_next  = '0;
            res0.data       = held_byte_reg;
            res0.first      = 1'b1;
            if (held_byte_reg == CH_DASH && b == CH_DASH) begin
                res0.kind  = KIND_COMMENT;
                res1.kind  = KIND_COMMENT;
                n_res      = 2'd2;
                mode_next  = MODE_COMMENT;
                phase_next = PH_DASH;
                close_next = 1'b0;
            end else if (held_byte_reg == CH_DOT && is_digit(b)) begin
                res0.kind = KIND_NUMBER;
                res1.kind = KIND_NUMBER;
                n_res     = 2'd2;
                mode_next = MODE_NUMBER;
            end else begin
                // The held byte stands alone; the new byte starts afresh.
                res0.kind = KIND_SYMBOL;
                lead      = 1'b1;
                do_start  = 1'b1;
            end
        end else begin
            n_res = 2'd1;
            case (mode_reg)
                MODE_IDENT:
                begin
                    res0.kind = KIND_IDENT;
                    do_start  = ~is_word(b);
                end
                MODE_NUMBER:
                begin
                    res0.kind = KIND_NUMBER;
                    do_start  = ~(is_word(b) || b == CH_DOT || b == CH_PLUS);
                end
                MODE_STRING:
                begin
                    res0.kind = KIND_STRING;
                    if (escape_reg) begin
                        escape_next = 1'b0;
                    end else if (b == CH_BSLASH) begin
                        escape_next = 1'b1;
                    end else if (b == (quote_dq_reg ? CH_DQUOTE : CH_SQUOTE)) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_SPACE:
                begin
                    res0.kind = KIND_SPACE;
                    do_start  = ~is_space(b);
                end
                MODE_COMMENT:
                begin
                    res0.kind = KIND_COMMENT;
                    if (phase_reg == PH_BLOCK) begin
                        if (b == CH_RBRACK && close_reg) begin
                            mode_next  = MODE_IDLE;
                            close_next = 1'b0;
                            phase_next = PH_DASH;
                        end else begin
                            close_next = (b == CH_RBRACK);
                        end
                    end else if (b == CH_NEWLINE) begin
                        phase_next = PH_DASH;
                        do_start   = 1'b1;
                    end else if (b == CH_LBRACK && phase_reg == PH_DASH) begin
                        phase_next = PH_BRACKET;
                    end else if (b == CH_LBRACK && phase_reg == PH_BRACKET) begin
                        phase_next = PH_BLOCK;
                        close_next = 1'b0;
                    end else begin
                        phase_next = PH_LINE;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase
        end

        if (do_start) begin
            mode_next = st.mode;
            n_res     = {1'b0, lead} + {1'b0, ~st.hold};
            if (st.hold) begin
                held_byte_next  = b;
                held_valid_next = 1'b1;
            end
            if (st.mode == MODE_STRING) begin
                quote_dq_next = st.quote_dq;
                escape_next   = 1'b0;
            end
            if (lead) begin
                res1.kind  = st.kind;
                res1.first = 1'b1;
            end else begin
                res0.kind  = st.kind;
                res0.first = 1'b1;
            end
        end

        // The last byte never holds, so at least one result exists here.
        if (fin) begin
            if (n_res == 2'd2) begin
                res1.done = 1'b1;
            end else begin
                res0.done = 1'b1;
            end
            mode_next       = MODE_IDLE;
            phase_next      = PH_DASH;
            close_next      = 1'b0;
            quote_dq_next   = 1'b0;
            escape_next     = 1'b0;
            held_byte_next  = '0;
            held_valid_next = 1'b0;
        end
    end

    // Queue pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
            count_next  = count_next + CNT_W'(n_res);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            phase_reg      <= PH_DASH;
            close_reg      <= 1'b0;
            quote_dq_reg   <= 1'b0;
            escape_reg     <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (accept) begin
                mode_reg       <= mode_next;
                phase_reg      <= phase_next;
                close_reg      <= close_next;
                quote_dq_reg   <= quote_dq_next;
                escape_reg     <= escape_next;
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && n_res == 2'd2) begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = queue_reg[rd_ptr_reg].data;
    assign m_axis_tuser  = {queue_reg[rd_ptr_reg].first, queue_reg[rd_ptr_reg].kind};
    assign m_axis_tlast  = queue_reg[rd_ptr_reg].done;

    // The queue never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

    // A byte is held only between tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (mode_reg == MODE_IDLE))
    else $error("held byte while inside a token");

    // The last byte of a source leaves the lexer at its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (!held_valid_reg && mode_reg == MODE_IDLE
                                      && phase_reg == PH_DASH && !escape_reg))
    else $error("lexer state not cleared after last byte");

    // An accepted item with a held byte pending always releases the held byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && held_valid_reg && !pop) |=> (count_reg > $past(count_reg)))
    else $error("held byte result lost");

endmodule
